// ===== design/mbph_pkg.sv =====
// ----------------------------------------------------------------------------
// mbph_pkg
// Shared types and constants for the level meter bank with peak hold.
// ----------------------------------------------------------------------------
package mbph_pkg;

   localparam int LVL_W          = 16;
   localparam int NUM_METERS_DEF = 8;

   // Command codes on req_command
   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Register indexes on the csr port
   localparam logic [2:0] REG_MIN_LEVEL     = 3'd0;
   localparam logic [2:0] REG_MAX_LEVEL     = 3'd1;
   localparam logic [2:0] REG_CLIP_ENABLE   = 3'd2;
   localparam logic [2:0] REG_RISE_STEP     = 3'd3;
   localparam logic [2:0] REG_DECAY_STEP    = 3'd4;
   localparam logic [2:0] REG_HOLD_TICKS    = 3'd5;
   localparam logic [2:0] REG_ACTIVE_METERS = 3'd6;

   // Reset values
   localparam logic signed [LVL_W-1:0] RST_MIN_LEVEL     = -16'sd15360;
   localparam logic signed [LVL_W-1:0] RST_MAX_LEVEL     = 16'sd0;
   localparam logic                    RST_CLIP_ENABLE   = 1'b1;
   localparam logic [LVL_W-1:0]        RST_RISE_STEP     = 16'd1280;
   localparam logic [LVL_W-1:0]        RST_DECAY_STEP    = 16'd12800;
   localparam logic [LVL_W-1:0]        RST_HOLD_TICKS    = 16'd0;
   localparam logic [3:0]              RST_ACTIVE_METERS = 4'd8;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== design/meter_ballistics_peak_hold.sv =====
// ----------------------------------------------------------------------------
// meter_ballistics_peak_hold
// Bank of level meters with rise/decay ballistics and peak hold.
// ----------------------------------------------------------------------------
// A set request writes one meter's target; it gives no result. A tick
// request while the timer runs walks the active meters one per cycle: busy
// stays high for the walk, and the N results (N = effective active meter
// count, 1 to NUM_METERS) follow one per cycle. The state register and then
// the result register lie between the accepted request and the first result.
// The walk rate is set by the meter memory, which is read and written back
// once per meter per cycle. A tick while the timer is stopped is taken and
// gives no result. Register writes are held off while a tick walk is under
// way. No clearing pass is needed after reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
module meter_ballistics_peak_hold
   import mbph_pkg::*;
#(
   parameter int NUM_METERS = NUM_METERS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_command,
   input  logic [2:0]              req_meter_index,
   input  logic signed [LVL_W-1:0] req_new_level,
   // result channel
   output logic                    rsp_valid,
   output logic [2:0]              rsp_meter_number,
   output logic signed [LVL_W-1:0] rsp_shown_level,
   output logic                    rsp_last,
   output logic                    rsp_all_settled,
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [LVL_W-1:0]        csr_wdata
);

   localparam int IDX_W = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;

   // registers
   logic signed [LVL_W-1:0] min_level_ff, max_level_ff;
   logic                    clip_enable_ff;
   logic [LVL_W-1:0]        rise_step_ff, decay_step_ff, hold_ticks_ff;
   logic [3:0]              active_meters_ff;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        proc_idx_ff, proc_idx_in;
   logic                    run_ff;
   logic                    settled_ff;

   // memories and their valid bits
   logic signed [LVL_W-1:0] tgt_mem [NUM_METERS];
   logic [2*LVL_W-1:0]      mtr_mem [NUM_METERS];
   logic signed [LVL_W-1:0] tgt_rd_ff;
   logic [2*LVL_W-1:0]      mtr_rd_ff;
   logic [NUM_METERS-1:0]   tgt_vld_ff, lvl_vld_ff, hold_vld_ff;

   // result registers
   logic                    rsp_valid_ff;
   logic [2:0]              rsp_num_ff;
   logic signed [LVL_W-1:0] rsp_lvl_ff;
   logic                    rsp_last_ff, rsp_settled_ff;

   logic                    accept, tick_go, set_go, scanning, at_last;
   logic [6:0]              act_ext, cnt_eff;
   logic [IDX_W-1:0]        last_idx, set_addr;
   logic signed [LVL_W-1:0] clamped;

   logic signed [LVL_W-1:0] cur_tgt, cur_lvl, new_lvl;
   logic [LVL_W-1:0]        cur_hold, new_hold;
   logic signed [LVL_W:0]   delta, dist_mag, lvl_down, lvl_up;
   logic                    meter_settled;

   assign csr_ready = !busy;

   // ---------------- request decode ----------------
   assign accept  = start && !busy;
   assign tick_go = accept && (req_command == CMD_TICK) && run_ff;
   assign set_go  = accept && (req_command == CMD_SET)
                    && ({4'b0, req_meter_index} < 7'(NUM_METERS));
   assign set_addr = IDX_W'({4'b0, req_meter_index});

   always_comb begin
      act_ext = {3'b0, active_meters_ff};
      if (act_ext == 7'd0) begin
         cnt_eff = 7'd1;
      end else if (act_ext > 7'(NUM_METERS)) begin
         cnt_eff = 7'(NUM_METERS);
      end else begin
         cnt_eff = act_ext;
      end
      last_idx = IDX_W'(cnt_eff - 7'd1);
   end

   always_comb begin
      clamped = req_new_level;
      if (clip_enable_ff) begin
         if (req_new_level < min_level_ff) begin
            clamped = min_level_ff;
         end else if (req_new_level > max_level_ff) begin
            clamped = max_level_ff;
         end
      end
   end

   // ---------------- sequencer ----------------
   assign at_last = (proc_idx_ff == last_idx);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_go) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (at_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      scanning    = 1'b0;
      proc_idx_in = '0;
      case (state_ff)
         ST_IDLE: begin
            proc_idx_in = '0;
         end
         ST_SCAN: begin
            scanning    = 1'b1;
            proc_idx_in = at_last ? '0 : proc_idx_ff + 1'b1;
         end
         default: begin
            proc_idx_in = '0;
         end
      endcase
   end

   assign busy = scanning;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         proc_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         proc_idx_ff <= proc_idx_in;
      end
   end

   // ---------------- meter update ----------------
   always_comb begin
      cur_tgt  = tgt_vld_ff[proc_idx_ff]  ? tgt_rd_ff : RST_MIN_LEVEL;
      cur_lvl  = lvl_vld_ff[proc_idx_ff]  ? $signed(mtr_rd_ff[2*LVL_W-1:LVL_W])
                                          : RST_MIN_LEVEL;
      cur_hold = hold_vld_ff[proc_idx_ff] ? mtr_rd_ff[LVL_W-1:0] : hold_ticks_ff;

      delta    = (LVL_W+1)'(cur_tgt) - (LVL_W+1)'(cur_lvl);
      dist_mag = -delta;
      lvl_down = (LVL_W+1)'(cur_lvl) - $signed({1'b0, decay_step_ff});
      lvl_up   = (LVL_W+1)'(cur_lvl) + $signed({1'b0, rise_step_ff});

      new_lvl       = cur_lvl;
      new_hold      = cur_hold;
      meter_settled = 1'b1;
      if (delta < 0) begin
         if (cur_hold == '0) begin
            if (dist_mag > $signed({1'b0, decay_step_ff})) begin
               new_lvl       = lvl_down[LVL_W-1:0];
               meter_settled = 1'b0;
            end else begin
               new_lvl = cur_tgt;
            end
         end else begin
            // hold the peak, count down
            new_hold      = cur_hold - 1'b1;
            meter_settled = 1'b0;
         end
      end else if (delta > 0) begin
         if (delta > $signed({1'b0, rise_step_ff})) begin
            new_lvl       = lvl_up[LVL_W-1:0];
            meter_settled = 1'b0;
         end else begin
            new_lvl = cur_tgt;
         end
         new_hold = hold_ticks_ff;
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (set_go) tgt_mem[set_addr] <= clamped;
      tgt_rd_ff <= tgt_mem[proc_idx_in];
   end

   always_ff @(posedge clock) begin
      if (scanning) mtr_mem[proc_idx_ff] <= {new_lvl, new_hold};
      mtr_rd_ff <= mtr_mem[proc_idx_in];
   end

   // ---------------- registers, valid bits, timer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff     <= RST_MIN_LEVEL;
         max_level_ff     <= RST_MAX_LEVEL;
         clip_enable_ff   <= RST_CLIP_ENABLE;
         rise_step_ff     <= RST_RISE_STEP;
         decay_step_ff    <= RST_DECAY_STEP;
         hold_ticks_ff    <= RST_HOLD_TICKS;
         active_meters_ff <= RST_ACTIVE_METERS;
         tgt_vld_ff       <= '0;
         lvl_vld_ff       <= '0;
         hold_vld_ff      <= '0;
         run_ff           <= 1'b0;
         settled_ff       <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MIN_LEVEL:     min_level_ff     <= $signed(csr_wdata);
               REG_MAX_LEVEL:     max_level_ff     <= $signed(csr_wdata);
               REG_CLIP_ENABLE:   clip_enable_ff   <= csr_wdata[0];
               REG_RISE_STEP:     rise_step_ff     <= csr_wdata;
               REG_DECAY_STEP:    decay_step_ff    <= csr_wdata;
               REG_HOLD_TICKS: begin
                  // every counter now reads as the new hold length
                  hold_ticks_ff <= csr_wdata;
                  hold_vld_ff   <= '0;
               end
               REG_ACTIVE_METERS: active_meters_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (set_go) begin
            tgt_vld_ff[set_addr] <= 1'b1;
            run_ff               <= 1'b1;
         end
         if (tick_go) begin
            settled_ff <= 1'b1;
         end
         if (scanning) begin
            lvl_vld_ff[proc_idx_ff]  <= 1'b1;
            hold_vld_ff[proc_idx_ff] <= 1'b1;
            settled_ff               <= settled_ff && meter_settled;
            if (at_last && settled_ff && meter_settled) run_ff <= 1'b0;
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= scanning;
      end
      rsp_num_ff     <= 3'(proc_idx_ff);
      rsp_lvl_ff     <= new_lvl;
      rsp_last_ff    <= at_last;
      rsp_settled_ff <= at_last && settled_ff && meter_settled;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_meter_number = rsp_num_ff;
   assign rsp_shown_level  = rsp_lvl_ff;
   assign rsp_last         = rsp_valid_ff && rsp_last_ff;
   assign rsp_all_settled  = rsp_valid_ff && rsp_settled_ff;

`ifndef SYNTHESIS
   a_settled_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_all_settled |-> rsp_last)
      else $error("all_settled without last");

   a_scan_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> rsp_valid)
      else $error("scanned meter gave no result");

   a_results_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && (rsp_meter_number == 3'($past(rsp_meter_number) + 3'd1))))
      else $error("result sequence broken");

   a_timer_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_all_settled |-> !run_ff)
      else $error("timer still running after settle");
`endif

endmodule

// ===== verif/tb_meter_ballistics_peak_hold.sv =====
// ----------------------------------------------------------------------------
// tb_meter_ballistics_peak_hold
// Self-checking bench for the meter bank. It drives set and tick requests and
// register writes with random gaps, tracks the meter levels, targets and hold
// counters alongside the block, and compares every meter report in order.
// ----------------------------------------------------------------------------
module tb_meter_ballistics_peak_hold;
   timeunit 1ns;
   timeprecision 1ps;

   import mbph_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int QUIET_CYCLES = 16;   // longer than the walk of the widest tick
   localparam int DRAIN_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;
   localparam int RANDOM_ITEMS = 88;
   localparam int PHASE_ITEMS  = 15;
   localparam int NO_CHECK     = -1;
   localparam int NUM_ROWS     = 35;

   // index past the end of the register list, written once to show it is ignored
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   // For register rows, sel is the register index and data the write value.
   typedef struct {
      row_kind_type kind;
      logic         cmd;
      logic [2:0]   sel;
      logic [15:0]  data;
      int           exp_count;
      int           exp_level0;
   } stim_row_type;

   typedef struct packed {
      logic [2:0]              meter;
      logic signed [LVL_W-1:0] level;
      logic                    last;
      logic                    settled;
   } meter_report_type;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    start           = 1'b0;
   logic                    busy;
   logic                    req_command     = CMD_SET;
   logic [2:0]              req_meter_index = '0;
   logic signed [LVL_W-1:0] req_new_level   = '0;
   logic                    rsp_valid;
   logic [2:0]              rsp_meter_number;
   logic signed [LVL_W-1:0] rsp_shown_level;
   logic                    rsp_last;
   logic                    rsp_all_settled;
   logic                    csr_valid       = 1'b0;
   logic                    csr_ready;
   logic [2:0]              csr_index       = '0;
   logic [LVL_W-1:0]        csr_wdata       = '0;

   // tracked block state
   logic signed [LVL_W-1:0] cfg_min;
   logic signed [LVL_W-1:0] cfg_max;
   logic                    cfg_clip;
   logic [LVL_W-1:0]        cfg_rise;
   logic [LVL_W-1:0]        cfg_decay;
   logic [LVL_W-1:0]        cfg_hold;
   logic [3:0]              cfg_active;
   logic signed [LVL_W-1:0] goal_level [NUM_METERS_DEF];
   logic signed [LVL_W-1:0] shown      [NUM_METERS_DEF];
   logic [LVL_W-1:0]        hold_left  [NUM_METERS_DEF];
   logic                    ticking;

   meter_report_type pending_reports[$];

   int mismatches      = 0;
   int reports_checked = 0;
   int requests_sent   = 0;
   int tick_walks      = 0;
   int csr_writes      = 0;

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 0, 0},
      '{ROW_REQ, CMD_SET, 3'd0, 16'sd32767, 0, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, -14080},
      '{ROW_REQ, CMD_SET, 3'd7, 16'h8000, 0, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, -12800},
      '{ROW_CSR, CMD_SET, REG_RISE_STEP, 16'hFFFF, NO_CHECK, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 0, 0},
      '{ROW_CSR, CMD_SET, REG_CLIP_ENABLE, 16'h0000, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_DECAY_STEP, 16'hFFFF, NO_CHECK, 0},
      '{ROW_REQ, CMD_SET, 3'd0, 16'h8000, 0, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, -32768},
      '{ROW_REQ, CMD_SET, 3'd0, 16'sd32767, 0, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, 32767},
      '{ROW_CSR, CMD_SET, REG_HOLD_TICKS, 16'd2, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_DECAY_STEP, 16'd256, NO_CHECK, 0},
      '{ROW_REQ, CMD_SET, 3'd0, 16'sd32512, 0, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, 32767},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, 32767},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 8, 32512},
      '{ROW_CSR, CMD_SET, REG_ACTIVE_METERS, 16'd0, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_MIN_LEVEL, 16'sd1000, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_MAX_LEVEL, -16'sd1000, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_CLIP_ENABLE, 16'd1, NO_CHECK, 0},
      '{ROW_REQ, CMD_SET, 3'd0, 16'h8000, 0, 0},
      '{ROW_REQ, CMD_SET, 3'd3, 16'sd32767, 0, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, 1, 32256},
      '{ROW_CSR, CMD_SET, REG_ACTIVE_METERS, 16'd15, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_UNUSED, 16'hFFFF, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_RISE_STEP, 16'd0, NO_CHECK, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, NO_CHECK, 0},
      '{ROW_REQ, CMD_SET, 3'd5, 16'h7FFF, NO_CHECK, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, NO_CHECK, 0},
      '{ROW_CSR, CMD_SET, REG_HOLD_TICKS, 16'hFFFF, NO_CHECK, 0},
      '{ROW_REQ, CMD_TICK, 3'd0, 16'h0000, NO_CHECK, 0}
   };

   meter_ballistics_peak_hold dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_meter_index  (req_meter_index),
      .req_new_level    (req_new_level),
      .rsp_valid        (rsp_valid),
      .rsp_meter_number (rsp_meter_number),
      .rsp_shown_level  (rsp_shown_level),
      .rsp_last         (rsp_last),
      .rsp_all_settled  (rsp_all_settled),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endfunction

   function automatic void reset_meters();
      cfg_min    = RST_MIN_LEVEL;
      cfg_max    = RST_MAX_LEVEL;
      cfg_clip   = RST_CLIP_ENABLE;
      cfg_rise   = RST_RISE_STEP;
      cfg_decay  = RST_DECAY_STEP;
      cfg_hold   = RST_HOLD_TICKS;
      cfg_active = RST_ACTIVE_METERS;
      for (int i = 0; i < NUM_METERS_DEF; i++) begin
         goal_level[i] = RST_MIN_LEVEL;
         shown[i]      = RST_MIN_LEVEL;
         hold_left[i]  = '0;
      end
      ticking = 1'b0;
   endfunction

   function automatic void apply_register(input logic [2:0] sel, input logic [LVL_W-1:0] value);
      case (sel)
         REG_MIN_LEVEL:     cfg_min = value;
         REG_MAX_LEVEL:     cfg_max = value;
         REG_CLIP_ENABLE:   cfg_clip = value[0];
         REG_RISE_STEP:     cfg_rise = value;
         REG_DECAY_STEP:    cfg_decay = value;
         REG_HOLD_TICKS: begin
            cfg_hold = value;
            for (int i = 0; i < NUM_METERS_DEF; i++) hold_left[i] = value;
         end
         REG_ACTIVE_METERS: cfg_active = value[3:0];
         default: ;
      endcase
   endfunction

   // Apply one accepted request and queue the meter reports it causes.
   function automatic void advance_meters(input logic cmd, input logic [2:0] sel,
                                          input logic signed [LVL_W-1:0] new_level,
                                          output int count, output int level0);
      logic signed [LVL_W-1:0] goal;
      int                      delta;
      int                      n;
      logic                    calm;
      meter_report_type        rpt;
      count  = 0;
      level0 = 0;
      calm   = 1'b1;
      if (cmd == CMD_SET) begin
         if (int'(sel) < NUM_METERS_DEF) begin
            goal = new_level;
            if (cfg_clip) begin
               if (goal < cfg_min) goal = cfg_min;
               else if (goal > cfg_max) goal = cfg_max;
            end
            goal_level[sel] = goal;
            ticking = 1'b1;
         end
         return;
      end
      if (!ticking) return;
      n = (cfg_active == 0) ? 1 : (cfg_active > NUM_METERS_DEF) ? NUM_METERS_DEF : cfg_active;
      for (int i = 0; i < n; i++) begin
         delta = int'(goal_level[i]) - int'(shown[i]);
         if (delta < 0) begin
            if (hold_left[i] == 0) begin
               if (-delta > int'(cfg_decay)) begin
                  shown[i] = shown[i] - cfg_decay;
                  calm = 1'b0;
               end else begin
                  shown[i] = goal_level[i];
               end
            end else begin
               hold_left[i] = hold_left[i] - 1'b1;
               calm = 1'b0;
            end
         end else if (delta > 0) begin
            if (delta > int'(cfg_rise)) begin
               shown[i] = shown[i] + cfg_rise;
               calm = 1'b0;
            end else begin
               shown[i] = goal_level[i];
            end
            hold_left[i] = cfg_hold;
         end
         rpt.meter   = i[2:0];
         rpt.level   = shown[i];
         rpt.last    = (i == n - 1);
         rpt.settled = (i == n - 1) && calm;
         pending_reports.push_back(rpt);
      end
      if (calm) ticking = 1'b0;
      count  = n;
      level0 = shown[0];
      tick_walks++;
   endfunction

   function automatic int pick_gap(input logic dense);
      int r;
      if (dense) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [LVL_W-1:0] rand_level();
      if ($urandom_range(0, 1) == 0) return LVL_W'($urandom_range(0, 65535));
      return LVL_W'($urandom_range(0, 18000) - 16000);
   endfunction

   function automatic logic [LVL_W-1:0] rand_register_value(input logic [2:0] sel);
      int pick;
      pick = $urandom_range(0, 99);
      case (sel)
         REG_MIN_LEVEL:
            return (pick < 80) ? LVL_W'($urandom_range(0, 16000) - 20000)
                               : LVL_W'($urandom_range(0, 65535));
         REG_MAX_LEVEL:
            return (pick < 80) ? LVL_W'($urandom_range(0, 12000) - 4000)
                               : LVL_W'($urandom_range(0, 65535));
         REG_CLIP_ENABLE:
            return LVL_W'($urandom_range(0, 1));
         REG_RISE_STEP, REG_DECAY_STEP: begin
            if (pick < 70) return LVL_W'($urandom_range(64, 6000));
            if (pick < 85) return LVL_W'($urandom_range(0, 65535));
            return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         end
         REG_HOLD_TICKS: begin
            if (pick < 70) return LVL_W'($urandom_range(0, 4));
            if (pick < 90) return LVL_W'($urandom_range(5, 40));
            return LVL_W'($urandom_range(0, 65535));
         end
         REG_ACTIVE_METERS:
            return LVL_W'($urandom_range(0, 15));
         default:
            return '0;
      endcase
   endfunction

   // Leaves start high when no gap follows, so a back-to-back request can reuse it.
   task automatic send_request(input logic cmd, input logic [2:0] sel,
                               input logic [LVL_W-1:0] new_level, input int gap,
                               output int count, output int level0);
      start           <= 1'b1;
      req_command     <= cmd;
      req_meter_index <= sel;
      req_new_level   <= new_level;
      do @(posedge clock); while (busy);
      advance_meters(cmd, sel, new_level, count, level0);
      requests_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start, wait out pending reports and any set still in flight.
   task automatic settle_block();
      start <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && pending_reports.size() > 0; w++) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] sel, input logic [LVL_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(sel, value);
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      meter_report_type want;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            note_mismatch($sformatf("unrequested report meter %0d level %0d last %0b settled %0b",
                                    rsp_meter_number, rsp_shown_level, rsp_last,
                                    rsp_all_settled));
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_meter_number !== want.meter || rsp_shown_level !== want.level ||
                rsp_last !== want.last || rsp_all_settled !== want.settled) begin
               note_mismatch($sformatf({"meter %0d level %0d last %0b settled %0b, ",
                                        "want meter %0d level %0d last %0b settled %0b"},
                                       rsp_meter_number, rsp_shown_level, rsp_last,
                                       rsp_all_settled, want.meter, want.level, want.last,
                                       want.settled));
            end
         end
      end
   end

   initial begin
      int   n;
      int   lvl0;
      int   random_sent;
      logic dense;
      logic cmd;
      logic [2:0] sel;
      reset_meters();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            write_register(directed_rows[r].sel, directed_rows[r].data);
         end else begin
            send_request(directed_rows[r].cmd, directed_rows[r].sel, directed_rows[r].data,
                         pick_gap(1'b0), n, lvl0);
            if (directed_rows[r].exp_count != NO_CHECK &&
                (n != directed_rows[r].exp_count ||
                 (n > 0 && lvl0 != directed_rows[r].exp_level0))) begin
               note_mismatch($sformatf("row %0d gives %0d reports, meter 0 at %0d; table %0d, %0d",
                                       r, n, lvl0, directed_rows[r].exp_count,
                                       directed_rows[r].exp_level0));
            end
         end
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         repeat ($urandom_range(2, 4)) begin
            sel = 3'($urandom_range(0, 6));
            write_register(sel, rand_register_value(sel));
         end
         dense = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < PHASE_ITEMS && random_sent < RANDOM_ITEMS; k++) begin
            cmd = ($urandom_range(0, 99) < 35) ? CMD_SET : CMD_TICK;
            send_request(cmd, 3'($urandom_range(0, 7)), rand_level(), pick_gap(dense),
                         n, lvl0);
            random_sent++;
         end
      end

      settle_block();
      if (pending_reports.size() > 0) begin
         note_mismatch($sformatf("%0d meter reports never arrived", pending_reports.size()));
      end
      $display("covered %0d requests with %0d tick walks and %0d register writes",
               requests_sent, tick_walks, csr_writes);
      $display("checked %0d meter reports, %0d mismatches", reports_checked, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== meter_ballistics_peak_hold.f =====
design/mbph_pkg.sv
design/meter_ballistics_peak_hold.sv
verif/tb_meter_ballistics_peak_hold.sv
